@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the sequencer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ec_seq_pkg.sv @@
// Types, codes and helpers shared by the embedded controller host sequencer.
`default_nettype none

package ec_seq_pkg;

    // Largest access that may be split into byte operations.
    localparam logic [3:0] MAX_ACCESS_BYTES = 4'd8;

    // Default number of result words the output queue holds.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Controller commands and status bits.
    localparam logic [7:0] CMD_READ   = 8'h80;
    localparam logic [7:0] CMD_WRITE  = 8'h81;
    localparam logic [7:0] CMD_QUERY  = 8'h84;
    localparam logic [7:0] ST_SCI_EVT = 8'h20;
    localparam logic [7:0] ST_IBF     = 8'h02;
    localparam logic [7:0] ST_OBF     = 8'h01;

    // Configuration register indexes and reset values.
    localparam logic CFG_COMMAND_PORT = 1'b0;
    localparam logic CFG_DATA_PORT    = 1'b1;
    localparam logic [15:0] COMMAND_PORT_RESET = 16'd102;
    localparam logic [15:0] DATA_PORT_RESET    = 16'd98;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_WAKE    = 2'd2,
        KIND_ABORT   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_PORT_WR  = 3'd0,
        ACT_PORT_RD  = 3'd1,
        ACT_DONE     = 3'd2,
        ACT_EVENT    = 3'd3,
        ACT_SPURIOUS = 3'd4,
        ACT_REJECT   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        DS_OK        = 2'd0,
        DS_BAD_PARAM = 2'd1,
        DS_ABORTED   = 2'd2
    } done_status_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_R_CMD    = 4'd1,
        PH_R_ADDR   = 4'd2,
        PH_R_DATA   = 4'd3,
        PH_W_CMD    = 4'd4,
        PH_W_ADDR   = 4'd5,
        PH_W_DATA   = 4'd6,
        PH_E_STATUS = 4'd7,
        PH_E_WAIT   = 4'd8,
        PH_E_DATA   = 4'd9
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        is_write;
        logic [15:0] address;
        logic [6:0]  width_bits;
        logic [63:0] write_value;
        logic [7:0]  port_byte;
    } in_word_t;

    typedef struct packed {
        action_t      action;
        logic [15:0]  port_select;
        logic [7:0]   out_byte;
        done_status_t done_status;
        logic [63:0]  read_value;
        logic [7:0]   query_code;
        logic         last;
    } out_word_t;

    typedef struct packed {
        phase_t      phase;
        logic        op_is_write;
        logic [7:0]  base_address;
        logic [3:0]  byte_total;
        logic [3:0]  byte_index;
        logic [63:0] pending_write_value;
        logic [63:0] read_accumulator;
        logic        event_seen;
    } seq_state_t;

    // Result words caused by one input word, in order.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } step_result_t;

    // Build a result word with the last mark clear.
    function automatic out_word_t mk_word(
        input action_t      action,
        input logic [15:0]  port_select,
        input logic [7:0]   out_byte,
        input done_status_t done_status,
        input logic [63:0]  read_value,
        input logic [7:0]   query_code
    );
        out_word_t w;
        w.action      = action;
        w.port_select = port_select;
        w.out_byte    = out_byte;
        w.done_status = done_status;
        w.read_value  = read_value;
        w.query_code  = query_code;
        w.last        = 1'b0;
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ec_host_transaction_sequencer.sv @@
// Top level of the embedded controller host transaction sequencer.
// Input words carry access requests, port bytes returned by earlier port
// reads, event wakeups and aborts. Each accepted word updates the sequence
// state in the same cycle and drops zero, one or two result words (port
// write, port read, access done, event code, spurious wakeup, rejected) into
// a small output queue; the final word of each input carries last.
// Result words are registered in the queue before they are offered on out_data.
// Throughput: one input word per cycle while the queue has room for two words;
// inputs that cause two results are held back by the queue, as the output side
// drains one word per cycle while out_ready is high.
// in_ready drops whenever the queue could not take two more words, so a
// stalled receiver backs the input side up without losing words.
// Configuration (command and data port addresses) is written through
// cfg_write_enable/cfg_index/cfg_data with no wait; the user must write it only
// while idle, which the block does not enforce. Reset returns the sequencer
// to idle, empties the queue and restores the port addresses 102 and 98.
`default_nettype none
`include "assert_macros.svh"

module ec_host_transaction_sequencer #(
    parameter int QUEUE_DEPTH = ec_seq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ec_seq_pkg::in_word_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ec_seq_pkg::out_word_t      out_data,
    input  wire logic                  cfg_write_enable,
    input  wire logic                  cfg_index,
    input  wire logic [15:0]           cfg_data
);
    import ec_seq_pkg::*;

    seq_state_t   state_reg;
    seq_state_t   state_next;
    step_result_t result;
    logic [15:0]  command_port_reg;
    logic [15:0]  data_port_reg;
    logic         in_fire;
    logic [1:0]   push_count;

    assign in_fire    = in_valid && in_ready;
    assign push_count = in_fire ? result.count : 2'd0;

    ec_seq_step u_step (
        .state             (state_reg),
        .in_data           (in_data),
        .command_port      (command_port_reg),
        .data_port_address (data_port_reg),
        .state_next        (state_next),
        .result            (result)
    );

    ec_seq_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push_first   (result.first),
        .push_second  (result.second),
        .room_for_two (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // Hold sequence state; advance it on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, op_is_write: 1'b0, base_address: 8'd0,
                           byte_total: 4'd0, byte_index: 4'd0,
                           pending_write_value: 64'd0, read_accumulator: 64'd0,
                           event_seen: 1'b0};
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Hold configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_port_reg <= COMMAND_PORT_RESET;
            data_port_reg    <= DATA_PORT_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_COMMAND_PORT: command_port_reg <= cfg_data;
                default:          data_port_reg    <= cfg_data;
            endcase
        end
    end

    `ASSERT_NEXT(a_abort_to_idle, clk, rst_n, in_fire && in_data.kind == KIND_ABORT,
        state_reg.phase == PH_IDLE, "abort did not return the sequencer to idle")
    `ASSERT_NEXT(a_busy_request_keeps_phase, clk, rst_n,
        in_fire && in_data.kind == KIND_REQUEST && state_reg.phase != PH_IDLE,
        state_reg.phase == $past(state_reg.phase),
        "request while busy disturbed the running sequence")
    `ASSERT_NEXT(a_wake_starts_poll, clk, rst_n,
        in_fire && in_data.kind == KIND_WAKE && state_reg.phase == PH_IDLE,
        state_reg.phase == PH_E_STATUS && out_valid,
        "wakeup while idle did not start a status poll")

endmodule

`default_nettype wire

@@ hw/rtl/ec_seq_out_queue.sv @@
// Result word queue: takes up to two words per cycle, hands out one while out_ready is high.
`default_nettype none
`include "assert_macros.svh"

module ec_seq_out_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [1:0]             push_count,
    input  wire ec_seq_pkg::out_word_t  push_first,
    input  wire ec_seq_pkg::out_word_t  push_second,
    output logic                        room_for_two,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ec_seq_pkg::out_word_t       out_data
);
    import ec_seq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    out_word_t         slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     wr_ptr_plus1;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              pop;

    // Advance a pointer with wrap at the queue depth.
    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
            r = '0;
        else
            r = p + AW'(1);
        return r;
    endfunction

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = slot_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= CW'(DEPTH - 2));

    // Work out pointer and fill updates.
    always_comb
    begin
        wr_ptr_plus1 = bump(wr_ptr_reg);
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = bump(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_count) - CW'(pop);
    end

    // Hold pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed words in order.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            slot_reg[wr_ptr_reg] <= push_first;
        if (push_count == 2'd2)
            slot_reg[wr_ptr_plus1] <= push_second;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH),
        "result queue overfilled")
    `ASSERT_ALWAYS(a_push_has_room, clk, rst_n,
        (push_count == 2'd0) || (count_reg + CW'(push_count) <= CW'(DEPTH)),
        "push into a result queue without room")
    `ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1,
        count_reg == $past(count_reg) + CW'($past(push_count)) - CW'($past(pop)),
        "result queue count does not track pushes and pops")

endmodule

`default_nettype wire

@@ hw/rtl/ec_seq_step.sv @@
// Next-state and result logic for one input word of the sequencer.
`default_nettype none

module ec_seq_step (
    input  wire ec_seq_pkg::seq_state_t   state,
    input  wire ec_seq_pkg::in_word_t     in_data,
    input  wire logic [15:0]              command_port,
    input  wire logic [15:0]              data_port_address,
    output ec_seq_pkg::seq_state_t        state_next,
    output ec_seq_pkg::step_result_t      result
);
    import ec_seq_pkg::*;

    logic [7:0]  cur_addr;
    logic [5:0]  shift;
    logic [3:0]  idx_inc;
    logic [63:0] acc_new;
    logic [7:0]  wr_byte;
    logic [3:0]  nbytes;
    logic        width_ok;
    logic [16:0] end_addr;
    logic [7:0]  status;
    logic        is_read_phase;

    always_comb
    begin
        cur_addr      = state.base_address + {4'd0, state.byte_index};
        shift         = {state.byte_index[2:0], 3'b000};
        idx_inc       = state.byte_index + 4'd1;
        status        = in_data.port_byte;
        acc_new       = state.read_accumulator | ({56'd0, status} << shift);
        wr_byte       = 8'(state.pending_write_value >> shift);
        nbytes        = in_data.width_bits[6:3];
        width_ok      = (in_data.width_bits == 7'd8) || (in_data.width_bits == 7'd16) ||
                        (in_data.width_bits == 7'd32) || (in_data.width_bits == 7'd64);
        end_addr      = {1'b0, in_data.address} + {13'd0, nbytes};
        is_read_phase = (state.phase == PH_R_CMD) || (state.phase == PH_R_ADDR) ||
                        (state.phase == PH_R_DATA);

        state_next    = state;
        result.count  = 2'd0;
        result.first  = mk_word(ACT_PORT_WR, 16'd0, 8'd0, DS_OK, 64'd0, 8'd0);
        result.second = mk_word(ACT_PORT_WR, 16'd0, 8'd0, DS_OK, 64'd0, 8'd0);

        case (in_data.kind)
            KIND_REQUEST:
            begin
                result.count = 2'd1;
                result.first = mk_word(ACT_REJECT, 16'd0, 8'd0, DS_BAD_PARAM, 64'd0, 8'd0);
                if (state.phase == PH_IDLE && width_ok && nbytes <= MAX_ACCESS_BYTES &&
                    end_addr <= 17'd256)
                begin
                    // Latch the access and send the first command byte.
                    state_next.op_is_write         = in_data.is_write;
                    state_next.base_address        = in_data.address[7:0];
                    state_next.byte_total          = nbytes;
                    state_next.byte_index          = 4'd0;
                    state_next.pending_write_value = in_data.write_value;
                    state_next.read_accumulator    = 64'd0;
                    state_next.phase = in_data.is_write ? PH_W_CMD : PH_R_CMD;
                    result.count  = 2'd2;
                    result.first  = mk_word(ACT_PORT_WR, command_port,
                                            in_data.is_write ? CMD_WRITE : CMD_READ,
                                            DS_OK, 64'd0, 8'd0);
                    result.second = mk_word(ACT_PORT_RD, command_port, 8'd0,
                                            DS_OK, 64'd0, 8'd0);
                end
            end
            KIND_BYTE:
            begin
                // Default reaction to a busy status: poll again.
                result.first = mk_word(ACT_PORT_RD, command_port, 8'd0, DS_OK, 64'd0, 8'd0);
                unique case (state.phase)
                    PH_R_CMD, PH_W_CMD:
                    begin
                        result.count = 2'd1;
                        if ((status & ST_IBF) == 8'd0)
                        begin
                            result.count  = 2'd2;
                            result.first  = mk_word(ACT_PORT_WR, data_port_address, cur_addr,
                                                    DS_OK, 64'd0, 8'd0);
                            result.second = mk_word(ACT_PORT_RD, command_port, 8'd0,
                                                    DS_OK, 64'd0, 8'd0);
                            state_next.phase = (state.phase == PH_R_CMD) ? PH_R_ADDR
                                                                         : PH_W_ADDR;
                        end
                    end
                    PH_R_ADDR, PH_E_WAIT:
                    begin
                        result.count = 2'd1;
                        if ((status & (ST_OBF | ST_IBF)) == ST_OBF)
                        begin
                            result.first = mk_word(ACT_PORT_RD, data_port_address, 8'd0,
                                                   DS_OK, 64'd0, 8'd0);
                            state_next.phase = (state.phase == PH_R_ADDR) ? PH_R_DATA
                                                                          : PH_E_DATA;
                        end
                    end
                    PH_W_ADDR:
                    begin
                        result.count = 2'd1;
                        if ((status & ST_IBF) == 8'd0)
                        begin
                            result.count  = 2'd2;
                            result.first  = mk_word(ACT_PORT_WR, data_port_address, wr_byte,
                                                    DS_OK, 64'd0, 8'd0);
                            result.second = mk_word(ACT_PORT_RD, command_port, 8'd0,
                                                    DS_OK, 64'd0, 8'd0);
                            state_next.phase = PH_W_DATA;
                        end
                    end
                    PH_R_DATA, PH_W_DATA:
                    begin
                        result.count = 2'd1;
                        if (state.phase == PH_R_DATA || (status & ST_IBF) == 8'd0)
                        begin
                            // Advance to the next byte or finish the access.
                            if (state.phase == PH_R_DATA)
                                state_next.read_accumulator = acc_new;
                            state_next.byte_index = idx_inc;
                            if (idx_inc >= state.byte_total)
                            begin
                                result.first = mk_word(ACT_DONE, 16'd0, 8'd0, DS_OK,
                                                       state.op_is_write ? 64'd0 : acc_new,
                                                       8'd0);
                                state_next.phase = PH_IDLE;
                            end
                            else
                            begin
                                result.count  = 2'd2;
                                result.first  = mk_word(ACT_PORT_WR, command_port,
                                                        state.op_is_write ? CMD_WRITE
                                                                          : CMD_READ,
                                                        DS_OK, 64'd0, 8'd0);
                                result.second = mk_word(ACT_PORT_RD, command_port, 8'd0,
                                                        DS_OK, 64'd0, 8'd0);
                                state_next.phase = state.op_is_write ? PH_W_CMD : PH_R_CMD;
                            end
                        end
                    end
                    PH_E_STATUS:
                    begin
                        if ((status & ST_SCI_EVT) != 8'd0)
                        begin
                            result.count  = 2'd2;
                            result.first  = mk_word(ACT_PORT_WR, command_port, CMD_QUERY,
                                                    DS_OK, 64'd0, 8'd0);
                            result.second = mk_word(ACT_PORT_RD, command_port, 8'd0,
                                                    DS_OK, 64'd0, 8'd0);
                            state_next.phase = PH_E_WAIT;
                        end
                        else
                        begin
                            // Report a wakeup that never carried an event.
                            if (!state.event_seen)
                            begin
                                result.count = 2'd1;
                                result.first = mk_word(ACT_SPURIOUS, 16'd0, 8'd0, DS_OK,
                                                       64'd0, 8'd0);
                            end
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_E_DATA:
                    begin
                        result.count  = 2'd2;
                        result.first  = mk_word(ACT_EVENT, 16'd0, 8'd0, DS_OK, 64'd0, status);
                        result.second = mk_word(ACT_PORT_RD, command_port, 8'd0,
                                                DS_OK, 64'd0, 8'd0);
                        state_next.event_seen = 1'b1;
                        state_next.phase      = PH_E_STATUS;
                    end
                    default:
                    begin
                        // Drop bytes that arrive while idle.
                        result.count = 2'd0;
                    end
                endcase
            end
            KIND_WAKE:
            begin
                if (state.phase == PH_IDLE)
                begin
                    state_next.event_seen = 1'b0;
                    state_next.phase      = PH_E_STATUS;
                    result.count = 2'd1;
                    result.first = mk_word(ACT_PORT_RD, command_port, 8'd0, DS_OK, 64'd0, 8'd0);
                end
            end
            default:
            begin
                // Abort the running sequence.
                if (state.phase != PH_IDLE)
                begin
                    result.count = 2'd1;
                    result.first = mk_word(ACT_DONE, 16'd0, 8'd0, DS_ABORTED,
                                           is_read_phase ? state.read_accumulator : 64'd0,
                                           8'd0);
                    state_next.phase = PH_IDLE;
                end
            end
        endcase

        // Mark the final word of this input.
        if (result.count == 2'd1)
            result.first.last = 1'b1;
        if (result.count == 2'd2)
            result.second.last = 1'b1;
    end

endmodule

`default_nettype wire
